// File: rtl/setq_pkg.sv
// setq_pkg: shared constants, codes and control struct for the sorted timer queue.
// No dependencies.
package setq_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned TIMER_SLOTS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF   = 32;

  // Fixed field widths.
  localparam int unsigned HANDLES   = 16;
  localparam int unsigned ID_W      = 4;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned IN_TIME_W = 32;
  // Positions 0..HANDLES (queue never holds more than HANDLES timers).
  localparam int unsigned CNT_W     = 5;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADJUST = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd3;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_DONE     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_EXPIRED  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NONE     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ABSENT   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PRESENT  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FULL     = 3'd5;

  // Sequencer to order-list control.
  typedef struct packed {
    logic             rm_en;
    logic [CNT_W-1:0] rm_pos;
    logic             ins_en;
    logic [CNT_W-1:0] ins_pos;
    logic [ID_W-1:0]  ins_id;
  } order_ctrl_t;

endpackage

// File: rtl/setq_in_if.sv
// setq_in_if / setq_out_if: valid-ready channels for commands and results.
// Depends on setq_pkg.
interface setq_in_if import setq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [ID_W-1:0]      timer_id;
  logic [IN_TIME_W-1:0] expire_time;
  logic [IN_TIME_W-1:0] current_time;

  modport source (output valid, func, timer_id, expire_time, current_time, input ready);
  modport sink   (input valid, func, timer_id, expire_time, current_time, output ready);
endinterface

// File: rtl/setq_out_if.sv
// setq_out_if: valid-ready channel for result transfers.
// Depends on setq_pkg.
interface setq_out_if import setq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   expired_id;
  logic              last;

  modport source (output valid, kind, expired_id, last, input ready);
  modport sink   (input valid, kind, expired_id, last, output ready);
endinterface

// File: rtl/setq_order_list.sv
// setq_order_list: row of handle cells kept in expiry order; shift-remove, shift-insert,
// one positional read and a handle search. Depends on setq_pkg.
module setq_order_list import setq_pkg::*; #(
  parameter int unsigned CAP = HANDLES
) (
  input  logic              clk_i,
  input  order_ctrl_t       ctrl_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic [CNT_W-1:0]  rd_pos_i,
  output logic [ID_W-1:0]   rd_id_o,
  input  logic [ID_W-1:0]   find_id_i,
  output logic [CNT_W-1:0]  find_pos_o
);

  localparam int unsigned IW = $clog2(CAP);

  logic [ID_W-1:0] ent_q [CAP];
  logic [ID_W-1:0] ent_d [CAP];

  always_comb begin
    for (int j = 0; j < CAP; j++) begin
      ent_d[j] = ent_q[j];
      if (ctrl_i.rm_en && (CNT_W'(j) >= ctrl_i.rm_pos) && (j + 1 < CAP)) begin
        ent_d[j] = ent_q[(j + 1) % CAP];
      end
      if (ctrl_i.ins_en) begin
        if (CNT_W'(j) == ctrl_i.ins_pos) begin
          ent_d[j] = ctrl_i.ins_id;
        end else if ((CNT_W'(j) > ctrl_i.ins_pos) && (j > 0)) begin
          ent_d[j] = ent_q[(j + CAP - 1) % CAP];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < CAP; j++) begin
      ent_q[j] <= ent_d[j];
    end
  end

  assign rd_id_o = (rd_pos_i < CNT_W'(CAP)) ? ent_q[rd_pos_i[IW-1:0]] : '0;

  // First queued cell holding the handle.
  always_comb begin
    logic found;
    found      = 1'b0;
    find_pos_o = '0;
    for (int j = 0; j < CAP; j++) begin
      if (!found && (CNT_W'(j) < count_i) && (ent_q[j] == find_id_i)) begin
        found      = 1'b1;
        find_pos_o = CNT_W'(j);
      end
    end
  end

endmodule

// File: rtl/setq_expiry_mem.sv
// setq_expiry_mem: expiry time per handle, one write and one registered read port.
// Depends on setq_pkg.
module setq_expiry_mem import setq_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ID_W-1:0]      waddr_i,
  input  logic [TIME_BITS-1:0] wdata_i,
  input  logic [ID_W-1:0]      raddr_i,
  output logic [TIME_BITS-1:0] rdata_o
);

  logic [TIME_BITS-1:0] mem [HANDLES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/sorted_expiry_timer_queue.sv
// Sorted timer queue, one command at a time. Add and adjust walk the timers ahead of the
// new spot with one compare each; delete unlinks the handle; rejects answer at once; a tick
// compares the head against now, removing and reporting each expired timer in turn.
// Output stalls hold the sequencer in S_EMIT; a waiting final
// result does not block the next command. Reset (async, active low) empties the queue.
// Depends on setq_pkg, setq_in_if, setq_out_if, setq_order_list, setq_expiry_mem.
module sorted_expiry_timer_queue import setq_pkg::*; #(
  parameter int unsigned TIMER_SLOTS = TIMER_SLOTS_DEF,
  parameter int unsigned TIME_BITS   = TIME_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  setq_in_if.sink    in_i,
  setq_out_if.source out_o
);

  // Usable depth: never more timers than handles.
  localparam int unsigned CAP = (TIMER_SLOTS < HANDLES) ? TIMER_SLOTS : HANDLES;

  typedef enum logic [2:0] {
    S_IDLE,    // waiting for a command
    S_UNLINK,  // pull the handle out of the list (adjust, delete)
    S_SCAN,    // walk the list for the insert spot
    S_TRD,     // tick: read head expiry
    S_TCMP,    // tick: compare head against now
    S_EMIT     // hand a result to the output register
  } state_e;

  state_e               state_q, state_d;
  logic [FUNC_W-1:0]    func_q, func_d;
  logic [ID_W-1:0]      id_q, id_d;
  logic [TIME_BITS-1:0] et_q, et_d, now_q, now_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [HANDLES-1:0]   mask_q, mask_d;
  logic [CNT_W-1:0]     idx_q, idx_d, cmp_idx_q, cmp_idx_d;
  logic                 pend_q, pend_d;
  logic [ID_W-1:0]      held_q, held_d;
  logic                 have_q, have_d;
  logic [KIND_W-1:0]    res_kind_q, res_kind_d;
  logic [ID_W-1:0]      res_id_q, res_id_d;
  logic                 res_last_q, res_last_d;
  logic                 out_vld_q, out_vld_d;
  logic [KIND_W-1:0]    out_kind_q, out_kind_d;
  logic [ID_W-1:0]      out_id_q, out_id_d;
  logic                 out_last_q, out_last_d;

  logic [TIME_BITS-1:0] et_in, now_in;
  order_ctrl_t          ctrl;
  logic [CNT_W-1:0]     rd_pos, find_pos;
  logic [ID_W-1:0]      rd_id;
  logic                 mem_we;
  logic [TIME_BITS-1:0] rdata, cmp_ref;
  logic                 cmp_gt, stop_gt;

  // Time fields are kept in TIME_BITS bits.
  if (TIME_BITS <= IN_TIME_W) begin : g_narrow
    assign et_in  = in_i.expire_time[TIME_BITS-1:0];
    assign now_in = in_i.current_time[TIME_BITS-1:0];
  end else begin : g_wide
    assign et_in  = {{(TIME_BITS - IN_TIME_W){1'b0}}, in_i.expire_time};
    assign now_in = {{(TIME_BITS - IN_TIME_W){1'b0}}, in_i.current_time};
  end

  setq_order_list #(.CAP(CAP)) u_order (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .count_i    (count_q),
    .rd_pos_i   (rd_pos),
    .rd_id_o    (rd_id),
    .find_id_i  (id_q),
    .find_pos_o (find_pos)
  );

  setq_expiry_mem #(.TIME_BITS(TIME_BITS)) u_exp (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (id_q),
    .wdata_i (et_q),
    .raddr_i (rd_id),
    .rdata_o (rdata)
  );

  // The one shared comparator: stored expiry vs. new expiry (insert) or now (tick).
  assign cmp_ref = (func_q == FUNC_TICK) ? now_q : et_q;
  assign cmp_gt  = rdata > cmp_ref;
  assign stop_gt = pend_q && cmp_gt;

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_vld_q;
  assign out_o.kind       = out_kind_q;
  assign out_o.expired_id = out_id_q;
  assign out_o.last       = out_last_q;

  always_comb begin
    state_d    = state_q;
    func_d     = func_q;
    id_d       = id_q;
    et_d       = et_q;
    now_d      = now_q;
    count_d    = count_q;
    mask_d     = mask_q;
    idx_d      = idx_q;
    cmp_idx_d  = cmp_idx_q;
    pend_d     = pend_q;
    held_d     = held_q;
    have_d     = have_q;
    res_kind_d = res_kind_q;
    res_id_d   = res_id_q;
    res_last_d = res_last_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    out_kind_d = out_kind_q;
    out_id_d   = out_id_q;
    out_last_d = out_last_q;
    ctrl       = '0;
    mem_we     = 1'b0;
    rd_pos     = idx_q;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          func_d     = in_i.func;
          id_d       = in_i.timer_id;
          et_d       = et_in;
          now_d      = now_in;
          idx_d      = '0;
          pend_d     = 1'b0;
          have_d     = 1'b0;
          res_id_d   = in_i.timer_id;
          res_last_d = 1'b1;
          case (in_i.func)
            FUNC_ADD: begin
              if (mask_q[in_i.timer_id]) begin
                res_kind_d = KIND_PRESENT;
                state_d    = S_EMIT;
              end else if (count_q >= CNT_W'(CAP)) begin
                res_kind_d = KIND_FULL;
                state_d    = S_EMIT;
              end else begin
                state_d = S_SCAN;
              end
            end
            FUNC_ADJUST, FUNC_DELETE: begin
              if (!mask_q[in_i.timer_id]) begin
                res_kind_d = KIND_ABSENT;
                state_d    = S_EMIT;
              end else begin
                state_d = S_UNLINK;
              end
            end
            FUNC_TICK: begin
              state_d = S_TRD;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_UNLINK: begin
        ctrl.rm_en     = 1'b1;
        ctrl.rm_pos    = find_pos;
        count_d        = count_q - CNT_W'(1);
        mask_d[id_q]   = 1'b0;
        if (func_q == FUNC_ADJUST) begin
          state_d = S_SCAN;
        end else begin
          res_kind_d = KIND_DONE;
          state_d    = S_EMIT;
        end
      end

      // Reads are pipelined: address for idx_q goes out while the data for
      // cmp_idx_q is compared. Insert after every entry at or below et.
      S_SCAN: begin
        if (stop_gt || (idx_q >= count_q)) begin
          ctrl.ins_en  = 1'b1;
          ctrl.ins_pos = stop_gt ? cmp_idx_q : count_q;
          ctrl.ins_id  = id_q;
          mem_we       = 1'b1;
          mask_d[id_q] = 1'b1;
          count_d      = count_q + CNT_W'(1);
          res_kind_d   = KIND_DONE;
          state_d      = S_EMIT;
        end else begin
          pend_d    = 1'b1;
          cmp_idx_d = idx_q;
          idx_d     = idx_q + CNT_W'(1);
        end
      end

      S_TRD: begin
        rd_pos = '0;
        if (count_q == '0) begin
          res_kind_d = have_q ? KIND_EXPIRED : KIND_NONE;
          res_id_d   = have_q ? held_q : '0;
          res_last_d = 1'b1;
          state_d    = S_EMIT;
        end else begin
          state_d = S_TCMP;
        end
      end

      // The previous expired handle is held back until the next head compare so its last flag is known.
      S_TCMP: begin
        rd_pos = '0;
        if (cmp_gt) begin
          res_kind_d = have_q ? KIND_EXPIRED : KIND_NONE;
          res_id_d   = have_q ? held_q : '0;
          res_last_d = 1'b1;
          state_d    = S_EMIT;
        end else begin
          ctrl.rm_en    = 1'b1;
          ctrl.rm_pos   = '0;
          count_d       = count_q - CNT_W'(1);
          mask_d[rd_id] = 1'b0;
          held_d        = rd_id;
          have_d        = 1'b1;
          if (have_q) begin
            res_kind_d = KIND_EXPIRED;
            res_id_d   = held_q;
            res_last_d = 1'b0;
            state_d    = S_EMIT;
          end else begin
            state_d = S_TRD;
          end
        end
      end

      S_EMIT: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d  = 1'b1;
          out_kind_d = res_kind_q;
          out_id_d   = res_id_q;
          out_last_d = res_last_q;
          state_d    = res_last_q ? S_IDLE : S_TRD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      mask_q    <= '0;
      pend_q    <= 1'b0;
      have_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      mask_q    <= mask_d;
      pend_q    <= pend_d;
      have_q    <= have_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    id_q       <= id_d;
    et_q       <= et_d;
    now_q      <= now_d;
    idx_q      <= idx_d;
    cmp_idx_q  <= cmp_idx_d;
    held_q     <= held_d;
    res_kind_q <= res_kind_d;
    res_id_q   <= res_id_d;
    res_last_q <= res_last_d;
    out_kind_q <= out_kind_d;
    out_id_q   <= out_id_d;
    out_last_q <= out_last_d;
  end

endmodule

// File: rtl/setq_checker.sv
// setq_props: port-level checks on the sorted timer queue, bound to the top level.
// Depends on setq_pkg and sorted_expiry_timer_queue.
module setq_props import setq_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] out_kind,
  input logic [ID_W-1:0]   out_id,
  input logic              out_last
);

  // Pending result holds until transferred.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_id)
                                && $stable(out_last))
    else $error("result changed while stalled");

  // One command at a time: busy right after a transfer in.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("ready after command transfer");

  // Only expired results may continue a train.
  a_train: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_last |-> out_kind == KIND_EXPIRED)
    else $error("non-last result is not an expiry");

  // A 'none' result names handle zero.
  a_none_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind == KIND_NONE |-> out_id == '0 && out_last)
    else $error("bad none result");

endmodule

bind sorted_expiry_timer_queue setq_props u_setq_props (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_kind  (out_o.kind),
  .out_id    (out_o.expired_id),
  .out_last  (out_o.last)
);
